### design/atf_pkg.sv
// ----------------------------------------------------------------------------
// atf_pkg
// Shared constants, codes and types of the ARMA texture filter.
// ----------------------------------------------------------------------------
package atf_pkg;

  localparam int AR_TAPS  = 16;
  localparam int MA_TAPS  = 16;
  localparam int MAX_TAPS = (AR_TAPS > MA_TAPS) ? AR_TAPS : MA_TAPS;

  localparam int KIND_W     = 2;
  localparam int INDEX_W    = 4;
  localparam int COEF_W     = 20;
  localparam int SAMPLE_W   = 24;
  localparam int COUNT_W    = 5;
  localparam int GAIN_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int AR_IW  = (AR_TAPS > 1) ? $clog2(AR_TAPS) : 1;
  localparam int MA_IW  = (MA_TAPS > 1) ? $clog2(MA_TAPS) : 1;
  localparam int TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int DEPTH  = AR_TAPS + MA_TAPS;
  localparam int MEM_AW = $clog2(DEPTH);

  localparam int FRAC_SHIFT  = 16;
  localparam int GAIN_HALF_W = GAIN_W / 2;
  localparam int MCLAMP_W    = 32;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_MIN_W   = MCLAMP_W + FRAC_SHIFT + 1;
  localparam int ACC_RAW_W   = PROD_W + $clog2(MAX_TAPS + 1) + 1;
  localparam int ACC_W       = (ACC_RAW_W > ACC_MIN_W) ? ACC_RAW_W : ACC_MIN_W;
  localparam int R12_W       = ACC_W - FRAC_SHIFT;
  localparam int GPROD_W     = MCLAMP_W + GAIN_HALF_W + 1;
  localparam int GSUM_W      = MCLAMP_W + GAIN_W + 1;
  localparam int M12_W       = GSUM_W - FRAC_SHIFT;
  localparam int Y_W         = ((M12_W > R12_W) ? M12_W : R12_W) + 1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  typedef enum logic [KIND_W-1:0] {
    KIND_STEP    = 2'd0,
    KIND_LOAD_AR = 2'd1,
    KIND_LOAD_MA = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AR_COUNT    = 2'd0,
    CFG_MA_COUNT    = 2'd1,
    CFG_ARMA_MODE   = 2'd2,
    CFG_FILTER_GAIN = 2'd3
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AR_RUN,
    ST_MA_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_GAIN_HI,
    ST_GAIN_LO,
    ST_COMBINE,
    ST_EMIT
  } state_e;

endpackage

### design/atf_in_if.sv
// ----------------------------------------------------------------------------
// atf_in_if
// Input channel: step and coefficient load words with valid/ready.
// ----------------------------------------------------------------------------
interface atf_in_if import atf_pkg::*;
  ();

  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic [INDEX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic signed [SAMPLE_W-1:0] excitation;

  modport source (output valid, kind, coef_index, coef_value, excitation, input ready);
  modport sink (input valid, kind, coef_index, coef_value, excitation, output ready);

endinterface

### design/atf_out_if.sv
// ----------------------------------------------------------------------------
// atf_out_if
// Output channel: filtered sample words with valid/ready.
// ----------------------------------------------------------------------------
interface atf_out_if import atf_pkg::*;
  ();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       clipped;

  modport source (output valid, sample, clipped, input ready);
  modport sink (input valid, sample, clipped, output ready);

endinterface

### design/arma_texture_filter.sv
// ----------------------------------------------------------------------------
// arma_texture_filter
// ARMA filter for vibration texture synthesis, one shared multiply-accumulate
// walking coefficient and history memories, histories kept as ring buffers.
// ----------------------------------------------------------------------------
// A step word walks the AR taps and then, in ARMA mode only, the MA taps over
// the memories, one tap a cycle, na and nm taps where these are the tap counts
// in use. The next word is accepted only after the result enters the output
// register, so no word is taken while a step is in flight. Reset clears the
// coefficient valid bits and the history fill counts.
module arma_texture_filter import atf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  atf_in_if.sink                in_i,
  atf_out_if.source             out_o
);

  localparam logic signed [R12_W-1:0] M_POS_LIM = R12_W'(64'sd2147483647);
  localparam logic signed [R12_W-1:0] M_NEG_LIM = -M_POS_LIM;
  localparam logic signed [Y_W-1:0]   Y_MAX     = Y_W'(64'sd8388607);
  localparam logic signed [Y_W-1:0]   Y_MIN     = -Y_MAX - Y_W'(1);
  localparam logic signed [ACC_W-1:0] ACC_HALF  = ACC_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [GSUM_W-1:0] G_HALF   = GSUM_W'(1) <<< (FRAC_SHIFT - 1);

  // Configuration registers.
  logic [COUNT_W-1:0] ar_count_q, ma_count_q;
  logic               arma_mode_q;
  logic [GAIN_W-1:0]  gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ar_count_q  <= '0;
      ma_count_q  <= '0;
      arma_mode_q <= 1'b0;
      gain_q      <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_AR_COUNT:    ar_count_q  <= cfg_wdata_i[COUNT_W-1:0];
        CFG_MA_COUNT:    ma_count_q  <= cfg_wdata_i[COUNT_W-1:0];
        CFG_ARMA_MODE:   arma_mode_q <= cfg_wdata_i[0];
        CFG_FILTER_GAIN: gain_q      <= cfg_wdata_i[GAIN_W-1:0];
      endcase
    end
  end

  state_e state_q, state_d;

  logic [TAP_W-1:0] tap_q, tap_d;
  logic [TAP_W-1:0] na_q, nm_q;
  logic [TAP_W-1:0] len_ar_q, len_ma_q;
  logic [AR_IW-1:0] head_ar_q, walk_ar_q, walk_ar_d, nh_ar;
  logic [MA_IW-1:0] head_ma_q, walk_ma_q, walk_ma_d, nh_ma;
  logic [TAP_W-1:0] na_in, nm_in, len_ar_min, len_ma_min;

  logic s1_vld_q, s1_ma_q, s1_hok_q;
  logic s2_vld_q, s2_ma_q;
  logic issue, issue_ma, hist_ok;

  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [ACC_W-1:0]    acc_ar_q, acc_ma_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [R12_W-1:0]    ar12_q;
  logic signed [MCLAMP_W-1:0] mclamp_q;
  logic signed [GPROD_W-1:0]  ph_q, pl_q;
  logic signed [M12_W-1:0]    m12_q;

  logic signed [ACC_W-1:0]    ar_t, ma_t;
  logic signed [R12_W-1:0]    ma_r;
  logic signed [GSUM_W-1:0]   gsum;
  logic signed [Y_W-1:0]      y_full;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       y_clip;

  logic in_acc, step_acc, emit;

  // Coefficient memory: AR taps at the low addresses, MA taps above them.
  logic signed [COEF_W-1:0]   coef_mem [DEPTH];
  logic [DEPTH-1:0]           coef_vld_q;
  logic                       coef_we;
  logic [MEM_AW-1:0]          coef_waddr, coef_raddr;
  logic signed [COEF_W-1:0]   coef_rd_q;
  logic                       coef_rd_vld_q;

  // History memory: output ring at the low addresses, excitation ring above.
  logic signed [SAMPLE_W-1:0] hist_mem [DEPTH];
  logic                       hist_we;
  logic [MEM_AW-1:0]          hist_waddr, hist_raddr;
  logic signed [SAMPLE_W-1:0] hist_wdata, hist_rd_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign step_acc   = in_acc && (in_i.kind == KIND_STEP);

  assign na_in = (32'(ar_count_q) > AR_TAPS) ? TAP_W'(AR_TAPS) : TAP_W'(ar_count_q);
  assign nm_in = (32'(ma_count_q) > MA_TAPS) ? TAP_W'(MA_TAPS) : TAP_W'(ma_count_q);

  assign nh_ar = (head_ar_q == '0) ? AR_IW'(AR_TAPS - 1) : head_ar_q - AR_IW'(1);
  assign nh_ma = (head_ma_q == '0) ? MA_IW'(MA_TAPS - 1) : head_ma_q - MA_IW'(1);

  assign len_ar_min = (len_ar_q < na_q) ? len_ar_q : na_q;
  assign len_ma_min = (len_ma_q < nm_q) ? len_ma_q : nm_q;

  // Coefficient load decode.
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = MEM_AW'(in_i.coef_index);
    if (in_acc) begin
      case (in_i.kind)
        KIND_LOAD_AR: begin
          coef_we    = (32'(in_i.coef_index) < AR_TAPS);
          coef_waddr = MEM_AW'(in_i.coef_index);
        end
        KIND_LOAD_MA: begin
          coef_we    = (32'(in_i.coef_index) < MA_TAPS);
          coef_waddr = MEM_AW'(AR_TAPS + 32'(in_i.coef_index));
        end
        default: coef_we = 1'b0;
      endcase
    end
  end

  // Rounding and saturation arithmetic.
  always_comb begin
    ar_t   = acc_ar_q + ACC_HALF;
    ma_t   = acc_ma_q + ACC_HALF;
    ma_r   = ma_t[ACC_W-1:FRAC_SHIFT];
    gsum   = (GSUM_W'(ph_q) <<< FRAC_SHIFT) + GSUM_W'(pl_q) + G_HALF;
    y_full = Y_W'(m12_q) - Y_W'(ar12_q);
    y_clip = 1'b0;
    if (y_full > Y_MAX) begin
      y_sat  = SAMPLE_W'(Y_MAX);
      y_clip = 1'b1;
    end else if (y_full < Y_MIN) begin
      y_sat  = SAMPLE_W'(Y_MIN);
      y_clip = 1'b1;
    end else begin
      y_sat  = y_full[SAMPLE_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    tap_d      = tap_q;
    walk_ar_d  = walk_ar_q;
    walk_ma_d  = walk_ma_q;
    issue      = 1'b0;
    issue_ma   = 1'b0;
    hist_ok    = 1'b0;
    coef_raddr = MEM_AW'(tap_q);
    hist_raddr = MEM_AW'(walk_ar_q);
    hist_we    = 1'b0;
    hist_waddr = MEM_AW'(nh_ar);
    hist_wdata = y_sat;
    emit       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        tap_d     = '0;
        walk_ar_d = head_ar_q;
        walk_ma_d = head_ma_q;
        if (step_acc) begin
          if (na_in != '0) begin
            state_d = ST_AR_RUN;
          end else if (arma_mode_q && (nm_in != '0)) begin
            state_d = ST_MA_RUN;
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_AR_RUN: begin
        issue      = 1'b1;
        hist_ok    = (tap_q < len_ar_q);
        coef_raddr = MEM_AW'(tap_q);
        hist_raddr = MEM_AW'(walk_ar_q);
        walk_ar_d  = (walk_ar_q == AR_IW'(AR_TAPS - 1)) ? '0 : walk_ar_q + AR_IW'(1);
        if (tap_q == na_q - TAP_W'(1)) begin
          tap_d   = '0;
          state_d = (arma_mode_q && (nm_q != '0)) ? ST_MA_RUN : ST_DRAIN;
        end else begin
          tap_d   = tap_q + TAP_W'(1);
        end
      end
      ST_MA_RUN: begin
        issue      = 1'b1;
        issue_ma   = 1'b1;
        hist_ok    = (tap_q < len_ma_q);
        coef_raddr = MEM_AW'(AR_TAPS + 32'(tap_q));
        hist_raddr = MEM_AW'(AR_TAPS + 32'(walk_ma_q));
        walk_ma_d  = (walk_ma_q == MA_IW'(MA_TAPS - 1)) ? '0 : walk_ma_q + MA_IW'(1);
        if (tap_q == nm_q - TAP_W'(1)) begin
          tap_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          tap_d   = tap_q + TAP_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_d = ST_GAIN_HI;
      end
      ST_GAIN_HI: begin
        hist_we    = 1'b1;
        hist_waddr = MEM_AW'(AR_TAPS + 32'(nh_ma));
        hist_wdata = x_q;
        state_d    = ST_GAIN_LO;
      end
      ST_GAIN_LO: begin
        state_d = ST_COMBINE;
      end
      ST_COMBINE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_o.valid || out_o.ready) begin
          emit       = 1'b1;
          hist_we    = 1'b1;
          hist_waddr = MEM_AW'(nh_ar);
          hist_wdata = y_sat;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_q     <= '0;
      walk_ar_q <= '0;
      walk_ma_q <= '0;
      head_ar_q <= '0;
      head_ma_q <= '0;
      len_ar_q  <= '0;
      len_ma_q  <= '0;
      na_q      <= '0;
      nm_q      <= '0;
      s1_vld_q  <= 1'b0;
      s1_ma_q   <= 1'b0;
      s1_hok_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_ma_q   <= 1'b0;
      coef_vld_q    <= '0;
      coef_rd_vld_q <= 1'b0;
      out_o.valid   <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_q     <= tap_d;
      walk_ar_q <= walk_ar_d;
      walk_ma_q <= walk_ma_d;
      s1_vld_q  <= issue;
      s1_ma_q   <= issue_ma;
      s1_hok_q  <= hist_ok;
      s2_vld_q  <= s1_vld_q;
      s2_ma_q   <= s1_ma_q;
      coef_rd_vld_q <= coef_vld_q[coef_raddr];
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (step_acc) begin
        na_q <= na_in;
        nm_q <= nm_in;
      end
      if (emit) begin
        head_ar_q <= nh_ar;
        head_ma_q <= nh_ma;
        len_ar_q  <= (len_ar_min == TAP_W'(AR_TAPS)) ? len_ar_min : len_ar_min + TAP_W'(1);
        len_ma_q  <= (len_ma_min == TAP_W'(MA_TAPS)) ? len_ma_min : len_ma_min + TAP_W'(1);
        out_o.valid <= 1'b1;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  // Memories.
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_i.coef_value;
    end
    coef_rd_q <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd_q <= hist_mem[hist_raddr];
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (step_acc) begin
      x_q      <= in_i.excitation;
      acc_ar_q <= '0;
      acc_ma_q <= ACC_W'(in_i.excitation) <<< FRAC_SHIFT;
    end else if (s2_vld_q) begin
      if (s2_ma_q) begin
        acc_ma_q <= acc_ma_q + ACC_W'(prod_q);
      end else begin
        acc_ar_q <= acc_ar_q + ACC_W'(prod_q);
      end
    end
    prod_q <= (coef_rd_vld_q ? coef_rd_q : COEF_W'(0))
            * (s1_hok_q ? hist_rd_q : SAMPLE_W'(0));
    if (state_q == ST_ROUND) begin
      ar12_q <= ar_t[ACC_W-1:FRAC_SHIFT];
      if (ma_r > M_POS_LIM) begin
        mclamp_q <= MCLAMP_W'(M_POS_LIM);
      end else if (ma_r < M_NEG_LIM) begin
        mclamp_q <= MCLAMP_W'(M_NEG_LIM);
      end else begin
        mclamp_q <= ma_r[MCLAMP_W-1:0];
      end
    end
    if (state_q == ST_GAIN_HI) begin
      ph_q <= mclamp_q * $signed({1'b0, gain_q[GAIN_W-1:GAIN_HALF_W]});
    end
    if (state_q == ST_GAIN_LO) begin
      pl_q <= mclamp_q * $signed({1'b0, gain_q[GAIN_HALF_W-1:0]});
    end
    if (state_q == ST_COMBINE) begin
      m12_q <= arma_mode_q ? gsum[GSUM_W-1:FRAC_SHIFT] : M12_W'(x_q);
    end
    if (emit) begin
      out_o.sample  <= y_sat;
      out_o.clipped <= y_clip;
    end
  end

  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AR_RUN) |-> (tap_q < na_q))
    else $error("AR tap counter ran past the tap count");

  a_ma_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MA_RUN) |-> (tap_q < nm_q) && arma_mode_q)
    else $error("MA tap walk outside ARMA mode or past the tap count");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (!s1_vld_q && !s2_vld_q))
    else $error("Rounding started with products still in flight");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (out_o.valid && (state_q == ST_IDLE)))
    else $error("Result word not presented after emit");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_ar_q <= TAP_W'(AR_TAPS)) && (len_ma_q <= TAP_W'(MA_TAPS)))
    else $error("History fill count exceeds ring depth");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives step and coefficient load words into the ARMA texture filter and
// checks every output word against a behavioural model of the filter kept
// here or a typed row's word. A directed table comes first, then random phases
// with fresh register settings, coefficient sets and idling on both channels.
// ----------------------------------------------------------------------------
module testbench import atf_pkg::*; ();

  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_WORDS = 1250;
  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;
  localparam longint M_LIMIT = 64'sd2147483647;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } sample_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_op_e;

  typedef struct {
    row_op_e                    op;
    cfg_index_e                 reg_idx;
    logic [CFG_DATA_W-1:0]      reg_data;
    logic [KIND_W-1:0]          kind;
    logic [INDEX_W-1:0]         idx;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SAMPLE_W-1:0] x;
    bit                         typed;
    sample_word_t               want;
  } stim_row_t;

  localparam int NUM_ROWS = 29;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  atf_in_if  in_if ();
  atf_out_if out_if ();

  arma_texture_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #10 clk_i = ~clk_i;

  logic signed [COEF_W-1:0]   ar_coef [AR_TAPS];
  logic signed [COEF_W-1:0]   ma_coef [MA_TAPS];
  logic signed [SAMPLE_W-1:0] out_hist [AR_TAPS];
  logic signed [SAMPLE_W-1:0] exc_hist [MA_TAPS];
  logic [COUNT_W-1:0]         cur_ar_count;
  logic [COUNT_W-1:0]         cur_ma_count;
  logic                       cur_arma_mode;
  logic [GAIN_W-1:0]          cur_gain;

  sample_word_t expected_samples [$];
  int           mismatches = 0;
  bit           no_idle = 1'b0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h7FFFFF, 1'b1,
      '{24'h7FFFFF, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h800000, 1'b1,
      '{24'h800000, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h000000, 1'b1,
      '{24'h000000, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'hFFFFFF, 1'b1,
      '{24'hFFFFFF, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_UNUSED, 4'd15, 20'h7FFFF, 24'h7FFFFF, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_LOAD_AR, 4'd0, 20'hF0000, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_LOAD_AR, 4'd15, 20'h80000, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_LOAD_MA, 4'd0, 20'h7FFFF, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_LOAD_MA, 4'd15, 20'h80000, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_REG, CFG_AR_COUNT, 32'd1, KIND_STEP, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h000100, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h7FFFFF, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_REG, CFG_AR_COUNT, 32'hFFFFFFFF, KIND_STEP, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h800000, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h123456, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_REG, CFG_ARMA_MODE, 32'd1, KIND_STEP, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_REG, CFG_MA_COUNT, 32'd31, KIND_STEP, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_REG, CFG_FILTER_GAIN, 32'hFFFFFFFF, KIND_STEP, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h7FFFFF, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h800000, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_REG, CFG_FILTER_GAIN, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h400000, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_REG, CFG_MA_COUNT, 32'd1, KIND_STEP, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_REG, CFG_FILTER_GAIN, 32'h00010000, KIND_STEP, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h001000, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_REG, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_REG, CFG_ARMA_MODE, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_STEP, 4'd0, 20'h0, 24'h000ABC, 1'b1,
      '{24'h000ABC, 1'b0}},
    '{ROW_WORD, CFG_AR_COUNT, 32'd0, KIND_LOAD_AR, 4'd0, 20'h0, 24'h0, 1'b0,
      '{24'h0, 1'b0}}
  };

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic longint round_q16(input longint v);
    return (v + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
  endfunction

  // Applies one word to the filter state and returns the output word it
  // produces, if any.
  task automatic filter_word(input logic [KIND_W-1:0] kind,
                             input logic [INDEX_W-1:0] idx,
                             input logic signed [COEF_W-1:0] coef,
                             input logic signed [SAMPLE_W-1:0] x,
                             output bit produced, output sample_word_t res);
    int     na;
    int     nm;
    longint acc;
    longint ar12;
    longint m12;
    longint y;
    produced = 1'b0;
    res = '0;
    if (kind == KIND_LOAD_AR) begin
      if (idx < AR_TAPS) ar_coef[idx] = coef;
    end else if (kind == KIND_LOAD_MA) begin
      if (idx < MA_TAPS) ma_coef[idx] = coef;
    end else if (kind == KIND_STEP) begin
      na = (cur_ar_count > AR_TAPS) ? AR_TAPS : int'(cur_ar_count);
      nm = (cur_ma_count > MA_TAPS) ? MA_TAPS : int'(cur_ma_count);
      acc = 0;
      for (int i = 0; i < na; i++) acc += longint'(out_hist[i]) * longint'(ar_coef[i]);
      ar12 = round_q16(acc);
      if (cur_arma_mode) begin
        acc = longint'(x) <<< FRAC_SHIFT;
        for (int i = 0; i < nm; i++) acc += longint'(exc_hist[i]) * longint'(ma_coef[i]);
        m12 = round_q16(acc);
        if (m12 > M_LIMIT) m12 = M_LIMIT;
        else if (m12 < -M_LIMIT) m12 = -M_LIMIT;
        m12 = round_q16(m12 * longint'({32'd0, cur_gain}));
      end else begin
        m12 = longint'(x);
      end
      y = m12 - ar12;
      if (y > SAMPLE_MAX) begin
        y = SAMPLE_MAX;
        res.clipped = 1'b1;
      end else if (y < SAMPLE_MIN) begin
        y = SAMPLE_MIN;
        res.clipped = 1'b1;
      end
      for (int i = AR_TAPS - 1; i >= 1; i--) out_hist[i] = (i - 1 < na) ? out_hist[i - 1] : '0;
      out_hist[0] = y[SAMPLE_W-1:0];
      for (int i = MA_TAPS - 1; i >= 1; i--) exc_hist[i] = (i - 1 < nm) ? exc_hist[i - 1] : '0;
      exc_hist[0] = x;
      res.sample = y[SAMPLE_W-1:0];
      produced = 1'b1;
    end
  endtask

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] coef,
                           input logic signed [SAMPLE_W-1:0] x,
                           input bit typed, input sample_word_t typed_word);
    int           gap;
    bit           produced;
    sample_word_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.coef_index <= idx;
    in_if.coef_value <= coef;
    in_if.excitation <= x;
    do @(posedge clk_i); while (!in_if.ready);
    filter_word(kind, idx, coef, x, produced, predicted);
    if (produced) begin
      expected_samples.insert(expected_samples.size(), typed ? typed_word : predicted);
    end
  endtask

  // A load word gives no output word, so the block may still be busy after the
  // last expected word has arrived.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e reg_idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= reg_idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (reg_idx)
      CFG_AR_COUNT:    cur_ar_count = data[COUNT_W-1:0];
      CFG_MA_COUNT:    cur_ma_count = data[COUNT_W-1:0];
      CFG_ARMA_MODE:   cur_arma_mode = data[0];
      CFG_FILTER_GAIN: cur_gain = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [COUNT_W-1:0] draw_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return COUNT_W'(AR_TAPS);
      2: return '1;
      default: return COUNT_W'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] draw_coef(input int span);
    if (span == 0) return COEF_W'($urandom());
    return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_excitation();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return SAMPLE_W'(int'($urandom_range(0, 32767)) - 16384);
    if (pick < 17) return SAMPLE_W'($urandom());
    if (pick == 17) return 24'h7FFFFF;
    if (pick == 18) return 24'h800000;
    return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
  endfunction

  initial begin : stimulus
    int                span;
    int                phase_len;
    int                words_counted;
    int                pick;
    logic [31:0]       noise;
    logic [KIND_W-1:0] kind;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_AR_COUNT;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_STEP;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    in_if.excitation = '0;
    foreach (ar_coef[i]) ar_coef[i] = '0;
    foreach (ma_coef[i]) ma_coef[i] = '0;
    foreach (out_hist[i]) out_hist[i] = '0;
    foreach (exc_hist[i]) exc_hist[i] = '0;
    cur_ar_count  = '0;
    cur_ma_count  = '0;
    cur_arma_mode = 1'b0;
    cur_gain      = GAIN_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].op == ROW_REG) begin
        wait_idle();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
      end else begin
        send_word(directed_rows[r].kind, directed_rows[r].idx, directed_rows[r].coef,
                  directed_rows[r].x, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    words_counted = 0;
    while (words_counted < RANDOM_WORDS) begin
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      noise = $urandom();
      write_reg(CFG_AR_COUNT, {noise[31:COUNT_W], draw_count()});
      noise = $urandom();
      write_reg(CFG_MA_COUNT, {noise[31:COUNT_W], draw_count()});
      noise = $urandom();
      write_reg(CFG_ARMA_MODE, noise);
      case ($urandom_range(0, 4))
        0: noise = '0;
        1: noise = 32'h0001_0000;
        2: noise = '1;
        3: noise = $urandom_range(0, 32'h0002_0000);
        default: noise = $urandom();
      endcase
      write_reg(CFG_FILTER_GAIN, noise);
      case ($urandom_range(0, 2))
        0: span = 4096;
        1: span = 32768;
        default: span = 0;
      endcase
      if ($urandom_range(0, 1) == 1) begin
        for (int i = 0; i < AR_TAPS; i++) begin
          send_word(KIND_LOAD_AR, INDEX_W'(i), draw_coef(span), draw_excitation(), 1'b0, '0);
        end
        for (int i = 0; i < MA_TAPS; i++) begin
          send_word(KIND_LOAD_MA, INDEX_W'(i), draw_coef(span), draw_excitation(), 1'b0, '0);
        end
        words_counted += AR_TAPS + MA_TAPS;
      end
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) kind = KIND_STEP;
        else if (pick < 17) kind = KIND_LOAD_AR;
        else if (pick < 19) kind = KIND_LOAD_MA;
        else kind = KIND_UNUSED;
        send_word(kind, INDEX_W'($urandom()), draw_coef(span), draw_excitation(), 1'b0, '0);
        if (kind != KIND_UNUSED) words_counted++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : sample_sink
    int           stall;
    sample_word_t got;
    sample_word_t want;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      got.sample  = out_if.sample;
      got.clipped = out_if.clipped;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected word sample=%0d clipped=%0b",
                                  got.sample, got.clipped));
      end else begin
        want = expected_samples.pop_front();
        if (got.sample !== want.sample) begin
          report_mismatch($sformatf("sample %0d, expected %0d", got.sample, want.sample));
        end
        if (got.clipped !== want.clipped) begin
          report_mismatch($sformatf("clipped %0b, expected %0b", got.clipped, want.clipped));
        end
      end
    end
  end

  initial begin : watchdog
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
design/atf_pkg.sv
design/atf_in_if.sv
design/atf_out_if.sv
design/arma_texture_filter.sv
tb/testbench.sv
